// File: sv/cbts_pkg.sv
// Shared types, constants and the candidate segment table of the CAN bit timing solver.
package cbts_pkg;

	localparam int CLK_W    = 32;
	localparam int RATE_W   = 28;
	localparam int STATUS_W = 2;
	localparam int SEG1_W   = 5;
	localparam int SEG2_W   = 4;
	localparam int DIV_W    = 11;
	localparam int BT_W     = 5;
	localparam int IDX_W    = 4;
	localparam int TABLE_SIZE = 10;

	localparam int DEF_CANDIDATE_COUNT = 10;
	localparam int DEF_MAX_DIVIDER     = 1024;

	localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_INPUT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_START,
		S_WAIT,
		S_CHECK,
		S_OUT
	} state_t;

	function automatic logic [SEG1_W-1:0] seg1_of(input logic [IDX_W-1:0] idx);
		logic [SEG1_W-1:0] s;
		case (idx)
			4'd0: s = 5'd13;
			4'd1: s = 5'd12;
			4'd2: s = 5'd11;
			4'd3: s = 5'd10;
			4'd4: s = 5'd9;
			4'd5: s = 5'd8;
			4'd6: s = 5'd8;
			4'd7: s = 5'd7;
			4'd8: s = 5'd6;
			4'd9: s = 5'd5;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	function automatic logic [SEG2_W-1:0] seg2_of(input logic [IDX_W-1:0] idx);
		logic [SEG2_W-1:0] s;
		case (idx)
			4'd5: s = 4'd3;
			4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9: s = 4'd2;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

	// Bit time in time quanta: sync segment plus both phase segments.
	function automatic logic [BT_W-1:0] bit_time_of(input logic [IDX_W-1:0] idx);
		return BT_W'(1) + BT_W'(seg1_of(idx)) + BT_W'(seg2_of(idx));
	endfunction

endpackage

// File: sv/cbts_div.sv
// Iterative restoring divider, one quotient bit per cycle, shared by all candidates.
module cbts_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cbts_pkg::CLK_W-1:0] dividend,
	input  logic [cbts_pkg::CLK_W-1:0] divisor,
	output logic                      done,
	output logic [cbts_pkg::CLK_W-1:0] quotient,
	output logic [cbts_pkg::CLK_W-1:0] remainder
);
	import cbts_pkg::*;

	localparam int CNT_W = $clog2(CLK_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   count_q;
	logic [CLK_W-1:0]   rem_q;
	logic [CLK_W-1:0]   quo_q;
	logic [CLK_W-1:0]   den_q;
	logic [CLK_W:0]     shifted;
	logic [CLK_W+1:0]   diff;
	logic               fits;

	assign shifted = {rem_q, quo_q[CLK_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign fits    = ~diff[CLK_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= busy_q && (count_q == CNT_W'(1));
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= CNT_W'(CLK_W);
			end else if (busy_q) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CLK_W-1:0] : shifted[CLK_W-1:0];
			quo_q <= {quo_q[CLK_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: sv/can_bit_timing_solver.sv
// Top level of the CAN bit timing solver: request handshake, candidate sequencer and result register.
//
// A transaction on the input channel (in_valid high, in_stall low) carries a peripheral
// clock frequency and a wanted bit rate. The block then walks the candidate list of
// phase segment pairs in order. For each candidate it forms bit_rate times the bit
// time in the multiply state and runs one 32-bit divide on the shared restoring
// divider, which produces one quotient bit per cycle. Each candidate passes through
// multiply, divider start, 32 divide steps, done and check. The first candidate that
// divides exactly with a prescaler from 1 to MAX_DIVIDER ends the search.
// A zero clock or rate goes straight to the result register without a search;
// otherwise up to min(CANDIDATE_COUNT, 10) candidates are tried. One request is in
// flight at a time: in_stall stays high from the accepting edge until the result
// has been taken, and the next request can be taken in the cycle after that.
// The result waits in its output register with out_valid high for as long as
// out_stall is high, and the payload holds meanwhile.
// Reset returns the sequencer to idle; any request in flight is dropped.
module can_bit_timing_solver #(
	parameter int CANDIDATE_COUNT = cbts_pkg::DEF_CANDIDATE_COUNT,
	parameter int MAX_DIVIDER     = cbts_pkg::DEF_MAX_DIVIDER
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [cbts_pkg::CLK_W-1:0]    clock_hz,
	input  logic [cbts_pkg::RATE_W-1:0]   bit_rate,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cbts_pkg::STATUS_W-1:0] status,
	output logic [cbts_pkg::SEG1_W-1:0]   seg1_tq,
	output logic [cbts_pkg::SEG2_W-1:0]   seg2_tq,
	output logic [cbts_pkg::DIV_W-1:0]    clock_divider
);
	import cbts_pkg::*;

	localparam int SEARCH_COUNT = (CANDIDATE_COUNT < TABLE_SIZE) ? CANDIDATE_COUNT : TABLE_SIZE;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEARCH_COUNT - 1);
	localparam logic [CLK_W-1:0] MAX_DIV  = CLK_W'(MAX_DIVIDER);

	state_t state_q;
	state_t state_d;

	logic [CLK_W-1:0]        clk_q;
	logic [RATE_W-1:0]       rate_q;
	logic [CLK_W-1:0]        den_q;
	logic [IDX_W-1:0]        idx_q;
	logic [STATUS_W-1:0]     status_q;
	logic [SEG1_W-1:0]       seg1_q;
	logic [SEG2_W-1:0]       seg2_q;
	logic [DIV_W-1:0]        divider_q;

	logic                    accept;
	logic                    bad_input;
	logic                    hit;
	logic                    div_start;
	logic                    div_done;
	logic [CLK_W-1:0]        div_quo;
	logic [CLK_W-1:0]        div_rem;
	logic [RATE_W+BT_W-1:0]  product;

	cbts_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (clk_q),
		.divisor   (den_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign accept    = in_valid && !in_stall;
	assign bad_input = (clock_hz == '0) || (bit_rate == '0);
	assign product   = (RATE_W+BT_W)'(rate_q) * (RATE_W+BT_W)'(bit_time_of(idx_q));
	assign hit       = (div_rem == '0) && (div_quo != '0) && (div_quo <= MAX_DIV);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = bad_input ? S_OUT : S_MUL;
				end
			end
			S_MUL:   state_d = S_START;
			S_START: state_d = S_WAIT;
			S_WAIT: begin
				if (div_done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: state_d = (hit || idx_q == LAST_IDX) ? S_OUT : S_MUL;
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE:  in_stall  = 1'b0;
			S_START: div_start = 1'b1;
			S_OUT:   out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clk_q  <= clock_hz;
			rate_q <= bit_rate;
			idx_q  <= '0;
			if (bad_input) begin
				status_q  <= STATUS_BAD_INPUT;
				seg1_q    <= '0;
				seg2_q    <= '0;
				divider_q <= '0;
			end
		end
		if (state_q == S_MUL) begin
			den_q <= product[CLK_W-1:0];
		end
		if (state_q == S_CHECK) begin
			if (hit) begin
				status_q  <= STATUS_FOUND;
				seg1_q    <= seg1_of(idx_q);
				seg2_q    <= seg2_of(idx_q);
				divider_q <= div_quo[DIV_W-1:0];
			end else if (idx_q == LAST_IDX) begin
				status_q  <= STATUS_NOT_FOUND;
				seg1_q    <= '0;
				seg2_q    <= '0;
				divider_q <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	assign status        = status_q;
	assign seg1_tq       = seg1_q;
	assign seg2_tq       = seg2_q;
	assign clock_divider = divider_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall))
		else $error("Input taken while a result is pending.");

	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_FOUND) |-> (seg1_tq != '0 && seg2_tq != '0))
		else $error("Found result carries an empty segment.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STATUS_FOUND) |->
		(seg1_tq == '0 && seg2_tq == '0 && clock_divider == '0))
		else $error("Failed result carries timing values.");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_WAIT))
		else $error("Divider finished outside its wait state.");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (idx_q <= LAST_IDX))
		else $error("Candidate index past the end of the search.");

endmodule
